// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; include once per file that asserts
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/qsr_pkg.sv =====
// shared types and codes for the requeue work queue
// no dependencies
package qsr_pkg;

  // fixed field widths of the beats
  localparam int unsigned IN_ID_W = 16;
  localparam int unsigned FRONT_W = 16;
  localparam int unsigned OCC_W   = 7;

  // operation codes
  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_REQUEUE = 2'd2
  } op_e;

  // fault codes
  typedef enum logic [1:0] {
    FAULT_OK      = 2'd0,
    FAULT_MISSING = 2'd1,
    FAULT_FULL    = 2'd2
  } fault_e;

  // input beat
  typedef struct packed {
    logic [1:0]         op;
    logic [IN_ID_W-1:0] entry_id;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [FRONT_W-1:0] front_id;
    logic [OCC_W-1:0]   occupancy;
    logic               is_empty;
    logic [1:0]         fault;
  } out_beat_t;

endpackage

// ===== rtl/core/qsr_mem.sv =====
// single-write, single-read synchronous ram holding the queue entries
// registered read port, no reset on the storage
module qsr_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/qsr_ctrl.sv =====
// sequencer for the requeue work queue: search, close-up and append over the ram
// depends on qsr_pkg; drives the ports of qsr_mem
module qsr_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned ID_WIDTH    = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  qsr_pkg::in_beat_t              in_beat_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output qsr_pkg::out_beat_t             res_beat_o,
  output logic                           mem_we_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] mem_waddr_o,
  output logic [ID_WIDTH-1:0]            mem_wdata_o,
  output logic                           mem_re_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] mem_raddr_o,
  input  logic [ID_WIDTH-1:0]            mem_rdata_i
);

  import qsr_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_SHIFT  = 3'd2;
  localparam logic [2:0] ST_APPEND = 3'd3;
  localparam logic [2:0] ST_FRONT  = 3'd4;
  localparam logic [2:0] ST_WAIT   = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [1:0]          op_q, op_d;
  logic [ID_WIDTH-1:0] id_q, id_d;
  logic [1:0]          fault_q, fault_d;

  logic [ID_WIDTH-1:0] id_in;
  logic [CW-1:0]       idx_p1;
  logic [CW-1:0]       idx_p2;
  logic                hit;

  // ram address of queue position off, counted from the head
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] head, input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    begin
      sum = SW'(head) + SW'(off);
      if (sum >= SW'(QUEUE_DEPTH)) begin
        sum = sum - SW'(QUEUE_DEPTH);
      end
      return sum[AW-1:0];
    end
  endfunction

  assign id_in  = ID_WIDTH'(in_beat_i.entry_id);
  assign idx_p1 = CW'(idx_q) + CW'(1);
  assign idx_p2 = CW'(idx_q) + CW'(2);
  assign hit    = (mem_rdata_i == id_q);

  assign in_stall_o = (state_q != ST_IDLE);

  // sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    op_d        = op_q;
    id_d        = id_q;
    fault_d     = fault_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wrap(head_q, count_q);
    mem_wdata_o = id_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;
    res_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_beat_i.op;
          id_d    = id_in;
          fault_d = FAULT_OK;
          idx_d   = '0;
          state_d = ST_FRONT;
          case (in_beat_i.op)
            OP_ADD: begin
              if (count_q == CW'(QUEUE_DEPTH)) begin
                fault_d = FAULT_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = wrap(head_q, count_q);
                mem_wdata_o = id_in;
                count_d     = count_q + CW'(1);
              end
            end
            OP_REMOVE, OP_REQUEUE: begin
              if (count_q == '0) begin
                fault_d = FAULT_MISSING;
              end else begin
                // fetch the front entry to start the search
                mem_re_o    = 1'b1;
                mem_raddr_o = head_q;
                state_d     = ST_SEARCH;
              end
            end
            default: begin
              state_d = ST_FRONT;
            end
          endcase
        end
      end

      // compare one entry a cycle, next read already in flight
      ST_SEARCH: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = wrap(head_q, idx_p1);
        if (hit) begin
          if (idx_q == '0) begin
            // front entry: pop, and append again on requeue
            head_d = wrap(head_q, CW'(1));
            if (op_q == OP_REQUEUE) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = wrap(head_q, count_q);
              mem_wdata_o = id_q;
            end else begin
              count_d = count_q - CW'(1);
            end
            state_d = ST_FRONT;
          end else if (idx_p1 == count_q) begin
            // back entry: nothing moves
            if (op_q != OP_REQUEUE) begin
              count_d = count_q - CW'(1);
            end
            state_d = ST_FRONT;
          end else begin
            state_d = ST_SHIFT;
          end
        end else if (idx_p1 == count_q) begin
          fault_d = FAULT_MISSING;
          state_d = ST_FRONT;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end

      // close up: write entry idx+1 into idx, read idx+2
      ST_SHIFT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = wrap(head_q, CW'(idx_q));
        mem_wdata_o = mem_rdata_i;
        mem_re_o    = 1'b1;
        mem_raddr_o = wrap(head_q, idx_p2);
        if (idx_p2 == count_q) begin
          if (op_q == OP_REQUEUE) begin
            state_d = ST_APPEND;
          end else begin
            count_d = count_q - CW'(1);
            state_d = ST_FRONT;
          end
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end

      // requeued id goes into the last slot
      ST_APPEND: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = wrap(head_q, count_q - CW'(1));
        mem_wdata_o = id_q;
        state_d     = ST_FRONT;
      end

      // read the front entry for the result
      ST_FRONT: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = head_q;
        state_d     = ST_WAIT;
      end

      // hand the result to the output register
      ST_WAIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result beat
  always_comb begin
    res_beat_o.front_id  = (count_q == '0) ? '0 : FRONT_W'(mem_rdata_i);
    res_beat_o.occupancy = OCC_W'(count_q);
    res_beat_o.is_empty  = (count_q == '0);
    res_beat_o.fault     = fault_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // per-item working registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    op_q    <= op_d;
    id_q    <= id_d;
    fault_q <= fault_d;
  end

endmodule

// ===== rtl/core/fifo_state_queue_with_requeue.sv =====
// Sequence: an add or unused op goes from accept through the front read to the result
// register; a remove or requeue first searches the entries from the front, closes up the
// entries behind a middle match, and appends the id again when a middle entry is requeued.
// Throughput: one item at a time; the ram gives one read per cycle in the search and close-up
// walk, and the input stalls until the sequencer's result is taken by the output register.
// Reset: asynchronous active low; queue empty, ram contents left as they are.
module fifo_state_queue_with_requeue #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned ID_WIDTH    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  qsr_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qsr_pkg::out_beat_t out_beat_o
);

  import qsr_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  logic                res_valid;
  logic                res_ready;
  out_beat_t           res_beat;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [ID_WIDTH-1:0] mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [ID_WIDTH-1:0] mem_rdata;
  logic                out_valid_q;
  out_beat_t           out_beat_q;

  // entry storage
  qsr_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ID_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // operation sequencer
  qsr_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_beat_o  (res_beat),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // output register decouples the result beat from the sequencer
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_beat_q <= res_beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

// ===== rtl/core/qsr_checker.sv =====
// port-level checks for the requeue work queue, bound to the top level
// depends on qsr_pkg and assert_macros.svh
`include "assert_macros.svh"

module qsr_checker #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input qsr_pkg::out_beat_t out_beat_o
);

  import qsr_pkg::*;

  logic empty_beat;
  logic drop_beat;
  logic at_capacity;
  logic out_held;

  // conditions seen on the result channel
  assign empty_beat  = out_valid_o && out_beat_o.is_empty;
  assign drop_beat   = out_valid_o && (out_beat_o.fault == FAULT_FULL);
  assign at_capacity = (out_beat_o.occupancy == OCC_W'(QUEUE_DEPTH)) && !out_beat_o.is_empty;
  assign out_held    = out_valid_o && out_stall_i;

  // an empty queue reports no entries and a zero front id
  `ASSERT_IMPLIES(a_empty_occ, clk_i, rst_ni, empty_beat, out_beat_o.occupancy == '0)
  `ASSERT_IMPLIES(a_empty_front, clk_i, rst_ni, empty_beat, out_beat_o.front_id == '0)

  // a dropped add only happens with the queue at capacity
  `ASSERT_IMPLIES(a_full_occ, clk_i, rst_ni, drop_beat, at_capacity)

  // a stalled result beat holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_beat_o))

endmodule

bind fifo_state_queue_with_requeue qsr_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_qsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);

// ===== tb/sv/queue_result_checker.sv =====
// result checker for the requeue work queue: watches both channels, keeps its own
// copy of the queue and compares every result beat with the one it predicts
// depends on qsr_pkg
`timescale 1ns / 100ps

module queue_result_checker #(
  parameter int unsigned QUEUE_DEPTH  = 64,
  parameter int unsigned REPORT_LIMIT = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  qsr_pkg::in_beat_t  in_beat_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  qsr_pkg::out_beat_t out_beat_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        checked_o,
  output int unsigned        peak_fill_o
);
  import qsr_pkg::*;

  logic [IN_ID_W-1:0] held_ids[$];     // model of the queue, front at index 0
  out_beat_t          due_results[$];  // predicted results, oldest first
  int unsigned        fails;
  int unsigned        compared;
  int unsigned        deepest;

  // apply one input beat to the model queue and build the result it should give
  function automatic out_beat_t apply_beat(input in_beat_t beat);
    out_beat_t res;
    fault_e    flt;
    int        hit;
    hit = -1;
    flt = FAULT_OK;
    case (beat.op)
      OP_ADD: begin
        if (held_ids.size() >= QUEUE_DEPTH) begin
          flt = FAULT_FULL;
        end else begin
          held_ids.insert(held_ids.size(), beat.entry_id);
        end
      end
      OP_REMOVE, OP_REQUEUE: begin
        // walk from the back so the front-most match wins
        for (int i = held_ids.size() - 1; i >= 0; i--) begin
          if (held_ids[i] == beat.entry_id) hit = i;
        end
        if (hit < 0) begin
          flt = FAULT_MISSING;
        end else begin
          held_ids.delete(hit);
          if (beat.op == OP_REQUEUE) held_ids.insert(held_ids.size(), beat.entry_id);
        end
      end
      default: ;  // unused op code, queue untouched
    endcase
    res.front_id  = (held_ids.size() != 0) ? held_ids[0] : '0;
    res.occupancy = OCC_W'(held_ids.size());
    res.is_empty  = (held_ids.size() == 0);
    res.fault     = flt;
    return res;
  endfunction

  // track accepted beats on both sides
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      held_ids.delete();
      due_results.delete();
      fails    = 0;
      compared = 0;
      deepest  = 0;
    end else begin
      // input beat taken: predict its result
      if (in_valid_i && !in_stall_i) begin
        due_results.insert(due_results.size(), apply_beat(in_beat_i));
        if (held_ids.size() > deepest) deepest = held_ids.size();
      end
      // result beat taken: compare with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT) begin
            $display("%0t: result beat with nothing outstanding: front %h occ %0d empty %b fault %0d",
                     $time, out_beat_i.front_id, out_beat_i.occupancy, out_beat_i.is_empty,
                     out_beat_i.fault);
          end
        end else begin
          want = due_results[0];
          due_results.delete(0);
          compared++;
          if (out_beat_i.front_id !== want.front_id || out_beat_i.occupancy !== want.occupancy ||
              out_beat_i.is_empty !== want.is_empty || out_beat_i.fault !== want.fault) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
              $display("%0t: result %0d mismatch (expected/actual): front %h/%h occ %0d/%0d",
                       $time, compared, want.front_id, out_beat_i.front_id, want.occupancy,
                       out_beat_i.occupancy);
              $display("    empty %b/%b fault %0d/%0d", want.is_empty, out_beat_i.is_empty,
                       want.fault, out_beat_i.fault);
            end
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= due_results.size();
    checked_o    <= compared;
    peak_fill_o  <= deepest;
  end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top for the requeue work queue: directed and random beats with random
// gaps and stalls; verdict taken from queue_result_checker
// depends on qsr_pkg, fifo_state_queue_with_requeue and queue_result_checker
`timescale 1ns / 100ps

module tb;
  import qsr_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = 64;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned PHASES       = 17;
  localparam int unsigned PHASE_BEATS  = 100;
  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned RECENT_SIZE  = 8;
  localparam logic [1:0]  OP_NOP       = 2'd3;  // unused code, leaves the queue alone

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_beat_t    in_beat   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_beat;

  logic        tx_quiet  = 1'b0;
  logic        rx_quiet  = 1'b0;
  int unsigned rx_wait;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned peak_fill;
  int unsigned op_tally[4];
  int unsigned recent_at;
  logic [IN_ID_W-1:0] id_pool[POOL_SIZE];
  logic [IN_ID_W-1:0] recent_ids[RECENT_SIZE];

  always #10 clk = ~clk;

  fifo_state_queue_with_requeue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_WIDTH   (IN_ID_W)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_beat_o (out_beat)
  );

  queue_result_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) result_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_beat_i  (out_beat),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .peak_fill_o (peak_fill)
  );

  // result side: each taken beat draws how many cycles the next one is held
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rx_wait <= 0;
    end else if (out_valid && !out_stall) begin
      rx_wait <= rx_quiet ? 0 : $urandom_range(0, 3);
    end else if (out_valid && out_stall && rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
    end
  end

  always @(negedge clk) begin
    out_stall <= (rx_wait != 0);
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(input logic [1:0] code, input logic [IN_ID_W-1:0] ident);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{op: code, entry_id: ident};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    op_tally[code]++;
    if (code == OP_ADD) begin
      recent_ids[recent_at] = ident;
      recent_at = (recent_at + 1) % RECENT_SIZE;
    end
    @(negedge clk);
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // ids mostly from a small pool so that duplicates and hits are common
  function automatic logic [IN_ID_W-1:0] pick_id(input logic [1:0] code);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (code != OP_ADD && r < 40) return recent_ids[$urandom_range(0, RECENT_SIZE - 1)];
    if (r < 88) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    return IN_ID_W'($urandom);
  endfunction

  // one random phase, weighted toward adds by add_pct
  task automatic run_phase(input int unsigned add_pct, input int unsigned beats);
    int unsigned r;
    logic [1:0]  code;
    for (int unsigned n = 0; n < beats; n++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        code = OP_NOP;
      end else if (r < 3 + add_pct) begin
        code = OP_ADD;
      end else if ($urandom_range(0, 1) == 0) begin
        code = OP_REMOVE;
      end else begin
        code = OP_REQUEUE;
      end
      send_beat(code, pick_id(code));
    end
  endtask

  // run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    foreach (id_pool[k]) id_pool[k] = IN_ID_W'($urandom);
    id_pool[0] = '0;
    id_pool[1] = '1;
    foreach (recent_ids[k]) recent_ids[k] = id_pool[k];
    recent_at = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty queue, extremes, duplicates, front/middle/back positions
    send_beat(OP_REMOVE,  16'h1234);  // empty queue, not found
    send_beat(OP_REQUEUE, 16'h1234);  // empty queue, not found
    send_beat(OP_NOP,     16'h0000);
    send_beat(OP_ADD,     16'h0000);
    send_beat(OP_ADD,     16'hFFFF);
    send_beat(OP_ADD,     16'h5A5A);
    send_beat(OP_ADD,     16'hFFFF);  // duplicate id
    send_beat(OP_REQUEUE, 16'h0000);  // front moves to back
    send_beat(OP_REQUEUE, 16'hFFFF);  // front-most duplicate is taken
    send_beat(OP_ADD,     16'hA5A5);
    send_beat(OP_REQUEUE, 16'hA5A5);  // already at the back
    send_beat(OP_NOP,     16'hFFFF);
    send_beat(OP_REMOVE,  16'h0000);  // middle entry, rest closes up
    send_beat(OP_REMOVE,  16'h5A5A);  // front pop
    send_beat(OP_REMOVE,  16'h7777);  // not found
    send_beat(OP_REMOVE,  16'hFFFF);
    send_beat(OP_REMOVE,  16'hA5A5);  // back entry
    send_beat(OP_REMOVE,  16'hFFFF);  // queue empty again
    send_beat(OP_ADD,     16'h8001);
    send_beat(OP_REQUEUE, 16'h8001);  // single entry
    send_beat(OP_REMOVE,  16'h8001);
    wait_idle();

    // random: alternate fill, drain and balanced phases to reach full and empty
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      tx_quiet = (ph % 5 == 3);
      rx_quiet = (ph % 4 == 2);
      case (ph % 3)
        0:       run_phase(88, PHASE_BEATS);
        1:       run_phase(15, PHASE_BEATS);
        default: run_phase(50, PHASE_BEATS);
      endcase
      if (ph == PHASES / 2) wait_idle();
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d beats: %0d add, %0d remove, %0d requeue, %0d unused code",
             op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
             op_tally[OP_ADD], op_tally[OP_REMOVE], op_tally[OP_REQUEUE], op_tally[OP_NOP]);
    $display("checked %0d results, queue reached %0d of %0d entries",
             checked, peak_fill, QUEUE_DEPTH);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
